// ----- hdl/cst_pkg.sv -----
`default_nettype none
package cst_pkg;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_OP    = 3'd1,
    M_LINE  = 3'd2,
    M_BLOCK = 3'd3,
    M_WORD  = 3'd4,
    M_NUM   = 3'd5
  } mode_t;

  localparam logic [2:0] K_LINE    = 3'd0;
  localparam logic [2:0] K_BLOCK   = 3'd1;
  localparam logic [2:0] K_KEYWORD = 3'd2;
  localparam logic [2:0] K_IDENT   = 3'd3;
  localparam logic [2:0] K_NUMBER  = 3'd4;
  localparam logic [2:0] K_OPER    = 3'd5;
  localparam logic [2:0] K_PUNCT   = 3'd6;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam int NUM_KW = 9;

  // int, if, else, return, float, double, while, for, main
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    64'h0000_0000_0069_6E74,
    64'h0000_0000_0000_6966,
    64'h0000_0000_656C_7365,
    64'h0000_7265_7475_726E,
    64'h0000_0066_6C6F_6174,
    64'h0000_646F_7562_6C65,
    64'h0000_0077_6869_6C65,
    64'h0000_0000_0066_6F72,
    64'h0000_0000_6D61_696E
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd3, 4'd2, 4'd4, 4'd6, 4'd5, 4'd6, 4'd5, 4'd3, 4'd4
  };

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] start_pos;
    logic [31:0] token_len;
    logic [3:0]  keyword_id;
    logic [7:0]  lead_char;
    logic        with_equals;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t r0;
    result_t r1;
  } step_out_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    return b >= 8'h21 && b <= 8'h7E && !is_alpha(b) && !is_digit(b);
  endfunction

  function automatic logic is_op(input logic [7:0] b);
    return b == CH_PLUS || b == CH_MINUS || b == CH_STAR || b == CH_SLASH ||
           b == CH_EQ || b == CH_LT || b == CH_GT || b == CH_BANG;
  endfunction

  function automatic logic [3:0] kw_lookup(input logic [63:0] prefix, input logic [3:0] len);
    logic [3:0] id;
    id = 4'd0;
    for (int i = 0; i < NUM_KW; i++) begin
      if (len == KW_LEN[i] && prefix == KW_TEXT[i]) id = 4'(i + 1);
    end
    return id;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/c_like_source_tokenizer.sv -----
// Streaming tokenizer for a small C-like language. One source byte is taken per
// cycle on the slave side; each byte yields zero, one or two token descriptors,
// which leave through a four-entry result queue on the master side, one per
// cycle, tlast marking the last descriptor caused by a byte. A byte is taken
// whenever the queue has room for two descriptors, so the rate is one byte per
// cycle while the sink keeps up and that room lasts; two descriptors from one
// byte take two entries. Operators and '/' are held for one byte of lookahead,
// and s_tlast ends the text: the open token is flushed and positions restart at 0.
`default_nettype none
module c_like_source_tokenizer #(
  parameter int POS_WIDTH    = 32,
  parameter int PREFIX_BYTES = 7
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // in_byte
  input  wire logic        s_tlast,   // end_of_text
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // start_pos, token_len, keyword_id, lead_char,
                                      // with_equals
  output logic [2:0]       m_tuser,   // token_kind
  output logic             m_tlast    // last_of_run
);
  import cst_pkg::*;

  step_out_t  step;
  result_t    head;
  logic       accept, pop, not_empty;
  logic [2:0] level;

  assign s_tready = level <= 3'd2;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = not_empty;
  assign pop      = m_tvalid && m_tready;

  cst_scanner #(
    .POS_WIDTH    (POS_WIDTH),
    .PREFIX_BYTES (PREFIX_BYTES)
  ) u_scanner (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (s_tdata),
    .end_of_text (s_tlast),
    .step        (step)
  );

  cst_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .level     (level)
  );

  assign m_tdata = {3'b000, head.with_equals, head.lead_char, head.keyword_id,
                    head.token_len, head.start_pos};
  assign m_tuser = head.kind;
  assign m_tlast = head.last_of_run;

  a_level_max: assert property (@(posedge clk) disable iff (rst) level <= 3'd4)
    else $error("result queue overflow");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    step.valid1 |-> step.valid0 && !step.r0.last_of_run && step.r1.last_of_run)
    else $error("second descriptor without first");

  a_idle_level: assert property (@(posedge clk) disable iff (rst)
    (!step.valid0 && !pop) |=> $stable(level))
    else $error("queue level moved without transaction");

endmodule
`default_nettype wire

// ----- hdl/cst_scanner.sv -----
`default_nettype none
module cst_scanner #(
  parameter int POS_WIDTH    = 32,
  parameter int PREFIX_BYTES = 7
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        in_byte,
  input  wire logic              end_of_text,
  output cst_pkg::step_out_t     step
);
  import cst_pkg::*;

  localparam int PW = 8 * PREFIX_BYTES;
  localparam logic [POS_WIDTH-1:0] PB = POS_WIDTH'(PREFIX_BYTES);
  localparam logic [POS_WIDTH-1:0] ONE = POS_WIDTH'(1);
  localparam logic [POS_WIDTH-1:0] TWO = POS_WIDTH'(2);

  mode_t                scan_mode, mode_mid, scan_mode_next;
  logic                 star_seen, star_mid, star_seen_next;
  logic [PW-1:0]        word_prefix, prefix_mid, word_prefix_next;
  logic [POS_WIDTH-1:0] token_start, start_mid, token_start_next;
  logic [POS_WIDTH-1:0] token_count, count_mid, token_count_next;
  logic [7:0]           pending_op, op_mid, pending_op_next;
  logic [POS_WIDTH-1:0] byte_position, byte_position_next;

  logic rescan, ev_op1, ev_op2, ev_line, ev_block, ev_word, ev_num, ev_punct;
  logic [POS_WIDTH-1:0] blk_count;

  function automatic logic [POS_WIDTH-1:0] sat(input logic [POS_WIDTH-1:0] v);
    return (v == {POS_WIDTH{1'b1}}) ? v : v + ONE;
  endfunction

  function automatic logic [31:0] to32(input logic [POS_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  function automatic logic [3:0] word_kw(input logic [PW-1:0] p,
                                         input logic [POS_WIDTH-1:0] c);
    return (c <= PB) ? kw_lookup(64'(p), c[3:0]) : 4'd0;
  endfunction

  function automatic result_t mk(input logic [2:0] kind, input logic [POS_WIDTH-1:0] s,
                                 input logic [POS_WIDTH-1:0] l, input logic [3:0] kw,
                                 input logic [7:0] lead, input logic eq);
    result_t r;
    r.kind        = kind;
    r.start_pos   = to32(s);
    r.token_len   = to32(l);
    r.keyword_id  = kw;
    r.lead_char   = lead;
    r.with_equals = eq;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // next state
  always_comb begin
    mode_mid   = scan_mode;
    star_mid   = star_seen;
    prefix_mid = word_prefix;
    start_mid  = token_start;
    count_mid  = token_count;
    op_mid     = pending_op;
    rescan     = 1'b0;
    ev_op1     = 1'b0;
    ev_op2     = 1'b0;
    ev_line    = 1'b0;
    ev_block   = 1'b0;
    ev_word    = 1'b0;
    ev_num     = 1'b0;
    ev_punct   = 1'b0;
    blk_count  = star_seen ? sat(token_count) : token_count;

    unique case (scan_mode)
      M_OP: begin
        if (pending_op == CH_SLASH && in_byte == CH_SLASH) begin
          mode_mid  = M_LINE;
          start_mid = byte_position + ONE;
          count_mid = '0;
        end else if (pending_op == CH_SLASH && in_byte == CH_STAR) begin
          mode_mid  = M_BLOCK;
          start_mid = byte_position + ONE;
          count_mid = '0;
          star_mid  = 1'b0;
        end else if (in_byte == CH_EQ) begin
          ev_op2   = 1'b1;
          mode_mid = M_IDLE;
        end else begin
          ev_op1 = 1'b1;
          rescan = 1'b1;
        end
      end
      M_LINE: begin
        if (in_byte == CH_LF) begin
          ev_line  = 1'b1;
          mode_mid = M_IDLE;
        end else begin
          count_mid = sat(token_count);
        end
      end
      M_BLOCK: begin
        if (star_seen && in_byte == CH_SLASH) begin
          ev_block = 1'b1;
          mode_mid = M_IDLE;
          star_mid = 1'b0;
        end else if (in_byte == CH_STAR) begin
          star_mid  = 1'b1;
          count_mid = blk_count;
        end else begin
          star_mid  = 1'b0;
          count_mid = sat(blk_count);
        end
      end
      M_WORD: begin
        if (is_alpha(in_byte) || is_digit(in_byte) || in_byte == CH_UNDER) begin
          if (token_count < PB) prefix_mid = {word_prefix[PW-9:0], in_byte};
          count_mid = sat(token_count);
        end else begin
          ev_word = 1'b1;
          rescan  = 1'b1;
        end
      end
      M_NUM: begin
        if (is_digit(in_byte) || in_byte == CH_DOT) begin
          count_mid = sat(token_count);
        end else begin
          ev_num = 1'b1;
          rescan = 1'b1;
        end
      end
      default: rescan = 1'b1;
    endcase

    if (rescan) begin
      mode_mid = M_IDLE;
      if (is_space(in_byte)) begin
        mode_mid = M_IDLE;
      end else if (is_op(in_byte)) begin
        mode_mid  = M_OP;
        op_mid    = in_byte;
        start_mid = byte_position;
      end else if (is_alpha(in_byte) || in_byte == CH_UNDER) begin
        mode_mid   = M_WORD;
        start_mid  = byte_position;
        count_mid  = ONE;
        prefix_mid = PW'(in_byte);
      end else if (is_digit(in_byte)) begin
        mode_mid  = M_NUM;
        start_mid = byte_position;
        count_mid = ONE;
      end else if (is_punct(in_byte)) begin
        ev_punct = 1'b1;
      end
    end

    if (end_of_text) begin
      scan_mode_next     = M_IDLE;
      star_seen_next     = 1'b0;
      word_prefix_next   = '0;
      token_start_next   = '0;
      token_count_next   = '0;
      pending_op_next    = '0;
      byte_position_next = '0;
    end else begin
      scan_mode_next     = mode_mid;
      star_seen_next     = star_mid;
      word_prefix_next   = prefix_mid;
      token_start_next   = start_mid;
      token_count_next   = count_mid;
      pending_op_next    = op_mid;
      byte_position_next = byte_position + ONE;
    end
  end

  // results
  result_t ra, rb, rc;
  logic    va, vb, vc;
  logic [3:0] kw_a, kw_c;

  always_comb begin
    kw_a = word_kw(word_prefix, token_count);
    kw_c = word_kw(prefix_mid, count_mid);
    va   = ev_op1 || ev_op2 || ev_line || ev_block || ev_word || ev_num;
    ra   = mk(K_NUMBER, token_start, token_count, 4'd0, 8'd0, 1'b0);
    if (ev_op2)        ra = mk(K_OPER, token_start, TWO, 4'd0, pending_op, 1'b1);
    else if (ev_op1)   ra = mk(K_OPER, token_start, ONE, 4'd0, pending_op, 1'b0);
    else if (ev_line)  ra = mk(K_LINE, token_start, token_count, 4'd0, 8'd0, 1'b0);
    else if (ev_block) ra = mk(K_BLOCK, token_start, token_count, 4'd0, 8'd0, 1'b0);
    else if (ev_word)  ra = mk((kw_a != 4'd0) ? K_KEYWORD : K_IDENT, token_start,
                               token_count, kw_a, 8'd0, 1'b0);

    vb = ev_punct;
    rb = mk(K_PUNCT, byte_position, ONE, 4'd0, in_byte, 1'b0);

    vc = end_of_text && (mode_mid != M_IDLE);
    unique case (mode_mid)
      M_OP:    rc = mk(K_OPER, start_mid, ONE, 4'd0, op_mid, 1'b0);
      M_LINE:  rc = mk(K_LINE, start_mid, count_mid, 4'd0, 8'd0, 1'b0);
      M_BLOCK: rc = mk(K_BLOCK, start_mid, star_mid ? sat(count_mid) : count_mid,
                       4'd0, 8'd0, 1'b0);
      M_WORD:  rc = mk((kw_c != 4'd0) ? K_KEYWORD : K_IDENT, start_mid, count_mid,
                       kw_c, 8'd0, 1'b0);
      default: rc = mk(K_NUMBER, start_mid, count_mid, 4'd0, 8'd0, 1'b0);
    endcase

    step.valid0 = accept && (va || vb || vc);
    step.valid1 = accept && ((va && vb) || (va && vc) || (vb && vc));
    step.r0     = va ? ra : (vb ? rb : rc);
    step.r1     = (va && vb) ? rb : rc;
    step.r0.last_of_run = !step.valid1;
    step.r1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= M_IDLE;
      star_seen     <= 1'b0;
      word_prefix   <= '0;
      token_start   <= '0;
      token_count   <= '0;
      pending_op    <= '0;
      byte_position <= '0;
    end else if (accept) begin
      scan_mode     <= scan_mode_next;
      star_seen     <= star_seen_next;
      word_prefix   <= word_prefix_next;
      token_start   <= token_start_next;
      token_count   <= token_count_next;
      pending_op    <= pending_op_next;
      byte_position <= byte_position_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/cst_result_fifo.sv -----
`default_nettype none
module cst_result_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cst_pkg::step_out_t push,
  input  wire logic               pop,
  output cst_pkg::result_t        head,
  output logic                    not_empty,
  output logic [2:0]              level
);
  import cst_pkg::*;

  localparam int DEPTH = 4;

  result_t    mem [DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] push_n, level_next;

  assign push_n     = {2'b0, push.valid0} + {2'b0, push.valid1};
  assign level_next = level + push_n - {2'b0, pop};
  assign not_empty  = level != 3'd0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[1:0];
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid0) mem[wr_ptr] <= push.r0;
    if (push.valid1) mem[wr_ptr + 2'd1] <= push.r1;
  end

endmodule
`default_nettype wire
